@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the key matcher
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked at every clock edge out of reset
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/tlkm_pkg.sv @@
// ----------------------------------------------------------------------------
// tlkm_pkg
// Types, constants and pattern lookup for the trimmed line key matcher.
// ----------------------------------------------------------------------------
package tlkm_pkg;

    localparam int LINE_CAPACITY = 8192;
    localparam int NAME_LENGTH   = 59;
    localparam int ROM_SIZE      = 120;
    localparam int TAIL_LEN      = 5;
    localparam int PATTERN_TOTAL = NAME_LENGTH + 6;

    localparam int LINE_CNT_W = $clog2(LINE_CAPACITY + 1);
    localparam int POS_W      = 7;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_MATCH = 2'd1,
        PH_MISS  = 2'd2,
        PH_TAIL  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECTED = 2'd1,
        ST_PRESENT  = 2'd2,
        ST_ABSENT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BC_NEWLINE = 2'd0,
        BC_WS      = 2'd1,
        BC_TEXT    = 2'd2,
        BC_BAD     = 2'd3
    } t_byte_class;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        t_byte_class cls;
    } t_item;

    localparam logic [7:0] NAME_ROM [ROM_SIZE] = '{
        8'h64, 8'h65, 8'h2e, 8'h66, 8'h72, 8'h65, 8'h64, 8'h65, 8'h72, 8'h69,
        8'h6b, 8'h73, 8'h74, 8'h61, 8'h64, 8'h6c, 8'h65, 8'h72, 8'h2e, 8'h62,
        8'h69, 8'h74, 8'h77, 8'h61, 8'h72, 8'h64, 8'h65, 8'h6e, 8'h2d, 8'h61,
        8'h67, 8'h65, 8'h6e, 8'h74, 8'h2d, 8'h63, 8'h72, 8'h65, 8'h64, 8'h65,
        8'h6e, 8'h74, 8'h69, 8'h61, 8'h6c, 8'h2d, 8'h62, 8'h72, 8'h69, 8'h64,
        8'h67, 8'h65, 8'h2e, 8'h68, 8'h65, 8'h6c, 8'h70, 8'h65, 8'h72, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // quote, space, equals, space, open brace
    localparam logic [7:0] TAIL_ROM [TAIL_LEN] = '{8'h22, 8'h20, 8'h3d, 8'h20, 8'h7b};

    // Expected byte at a given key position; zero past the end never matches
    function automatic logic [7:0] pattern_at(input logic [POS_W-1:0] pos);
        logic [7:0]       res;
        logic [POS_W-1:0] off;
        res = 8'h00;
        off = pos - POS_W'(NAME_LENGTH + 1);
        if (pos == '0) begin
            res = CH_QUOTE;
        end else if (pos <= POS_W'(NAME_LENGTH)) begin
            res = NAME_ROM[pos - 1'b1];
        end else if (off < POS_W'(TAIL_LEN)) begin
            res = TAIL_ROM[off[2:0]];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/tlkm_front.sv @@
// ----------------------------------------------------------------------------
// tlkm_front
// Accepts snapshot bytes and tags each with its byte class for the queue.
// ----------------------------------------------------------------------------
module tlkm_front (
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_full,
    output logic                  o_push,
    output tlkm_pkg::t_item       o_item
);
    import tlkm_pkg::*;

    t_byte_class s_cls;

    always_comb begin
        if (i_s_tdata == CH_NEWLINE) begin
            s_cls = BC_NEWLINE;
        end else if (i_s_tdata == CH_SPACE || i_s_tdata == CH_TAB) begin
            s_cls = BC_WS;
        end else if (i_s_tdata > CH_SPACE && i_s_tdata <= CH_TILDE) begin
            s_cls = BC_TEXT;
        end else begin
            s_cls = BC_BAD;
        end
    end

    assign o_s_tready  = !i_full;
    assign o_push      = i_s_tvalid && !i_full;
    assign o_item.data = i_s_tdata;
    assign o_item.last = i_s_tlast;
    assign o_item.cls  = s_cls;

endmodule

@@ rtl/core/tlkm_fifo.sv @@
// ----------------------------------------------------------------------------
// tlkm_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlkm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlkm_pkg::t_item i_item,
    input  logic            i_pop,
    output tlkm_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import tlkm_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count,  n_count;
    logic            s_push, s_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = s_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = s_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (s_push && !s_pop) begin
            n_count = r_count + 1'b1;
        end else if (s_pop && !s_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_CLK(a_count_range, r_count <= Q_CW'(Q_DEPTH), "queue count beyond depth")
    `ASSERT_IMPL(a_push_room, i_push, !o_full, "push into full queue")

endmodule

@@ rtl/core/tlkm_back.sv @@
// ----------------------------------------------------------------------------
// tlkm_back
// Line matcher: trims, compares against the key, tracks marks, drives status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlkm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlkm_pkg::t_item i_item,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata     // [1:0] status, [7:2] zero
);
    import tlkm_pkg::*;

    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [LINE_CNT_W-1:0] r_line_count, n_line_count;
    logic                  r_found, n_found;
    logic                  r_rejected, n_rejected;
    logic                  s_found_upd, s_rej_upd;
    logic                  s_hit;
    logic [POS_W-1:0]      s_pos_inc;
    t_status               s_status;
    logic                  r_out_valid;
    t_status               r_out_status;

    assign o_pop     = !i_empty && (!r_out_valid || i_m_tready);
    assign s_hit     = (i_item.data == pattern_at(r_pos));
    assign s_pos_inc = r_pos + 1'b1;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_line_count = r_line_count;
        s_found_upd  = r_found;
        s_rej_upd    = r_rejected;
        if (o_pop && !r_rejected) begin
            unique case (i_item.cls)
                BC_NEWLINE: begin
                    if (r_phase == PH_TAIL) begin
                        s_found_upd = 1'b1;
                    end
                    n_phase      = PH_LEAD;
                    n_pos        = '0;
                    n_line_count = '0;
                end
                BC_BAD: begin
                    s_rej_upd = 1'b1;
                end
                BC_WS, BC_TEXT: begin
                    if (r_line_count >= LINE_CNT_W'(LINE_CAPACITY)) begin
                        s_rej_upd = 1'b1;
                    end else begin
                        n_line_count = r_line_count + 1'b1;
                        case (r_phase)
                            PH_LEAD, PH_MATCH: begin
                                // leading whitespace is skipped, not compared
                                if (r_phase == PH_MATCH || i_item.cls == BC_TEXT) begin
                                    if (s_hit) begin
                                        n_pos   = s_pos_inc;
                                        n_phase = (s_pos_inc >= POS_W'(PATTERN_TOTAL)) ?
                                                  PH_TAIL : PH_MATCH;
                                    end else begin
                                        n_phase = PH_MISS;
                                    end
                                end
                            end
                            PH_TAIL: begin
                                if (i_item.cls == BC_TEXT) begin
                                    n_phase = PH_MISS;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
        n_found    = s_found_upd;
        n_rejected = s_rej_upd;
        // end of snapshot: verdict given, everything clears
        if (o_pop && i_item.last) begin
            n_phase      = PH_LEAD;
            n_pos        = '0;
            n_line_count = '0;
            n_found      = 1'b0;
            n_rejected   = 1'b0;
        end
    end

    // outputs
    always_comb begin
        if (s_rej_upd) begin
            s_status = ST_REJECTED;
        end else if (!i_item.last) begin
            s_status = ST_OK;
        end else if (i_item.cls == BC_NEWLINE && s_found_upd) begin
            s_status = ST_PRESENT;
        end else begin
            s_status = ST_ABSENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_pos        <= '0;
            r_line_count <= '0;
            r_found      <= 1'b0;
            r_rejected   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_line_count <= n_line_count;
            r_found      <= n_found;
            r_rejected   <= n_rejected;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_status <= s_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_status};

    `ASSERT_NEXT(a_rej_sticky, o_pop && !i_item.last && s_rej_upd, r_rejected,
                 "rejection not held")
    `ASSERT_NEXT(a_found_sticky, r_found && !(o_pop && i_item.last), r_found,
                 "found mark lost within snapshot")
    `ASSERT_NEXT(a_end_clears, o_pop && i_item.last,
                 !r_found && !r_rejected && r_line_count == '0 && r_pos == '0,
                 "state not cleared after last byte")

endmodule

@@ rtl/core/trimmed_line_key_matcher_top.sv @@
// ----------------------------------------------------------------------------
// trimmed_line_key_matcher_top
// Byte-stream matcher flagging a trimmed key line in a text snapshot.
// ----------------------------------------------------------------------------
// Input channel (s): one snapshot byte per request in tdata[7:0], tlast on the
// final byte of the snapshot. Output channel (m): one status per input byte in
// tdata[1:0]: accepted, rejected (sticky), end with key present, end with key
// absent. After the final byte all matcher state clears for the next snapshot.
// A byte is taken into a four-entry queue and classified on the way in; the
// matcher pops one byte a cycle while the queue is not empty and the status
// register is free or being read, and registers its status there.
// Throughput: one byte per cycle while the receiver keeps taking statuses.
// Reset (synchronous, i_rst_n low) empties the queue, drops any pending
// status and clears all marks. When the receiver stalls the status holds and
// the queue keeps taking bytes until its four entries are full, then
// o_s_tready falls.
// ----------------------------------------------------------------------------
module trimmed_line_key_matcher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] data_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata     // [1:0] status, [7:2] zero
);
    import tlkm_pkg::*;

    t_item s_push_item;
    t_item s_head_item;
    logic  s_push, s_pop, s_full, s_empty;

    tlkm_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (s_full),
        .o_push     (s_push),
        .o_item     (s_push_item)
    );

    tlkm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_push_item),
        .i_pop   (s_pop),
        .o_item  (s_head_item),
        .o_full  (s_full),
        .o_empty (s_empty)
    );

    tlkm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (s_head_item),
        .i_empty    (s_empty),
        .o_pop      (s_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ dv/tlkm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlkm_checker
// Watches both stream channels of the trimmed line key matcher. Each accepted
// request is run through a local line matcher to get its expected status; each
// accepted status is compared in order against the oldest expected one.
// ----------------------------------------------------------------------------
module tlkm_checker
    import tlkm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] data_byte
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [1:0] status, [7:2] zero
    output int         o_fail_count,
    output int         o_pending
);

    localparam int KEY_NAME_BYTES = 59;

    // key name bytes, independent of the package ROM
    localparam logic [7:0] KEY_NAME [KEY_NAME_BYTES] = '{
        8'h64, 8'h65, 8'h2e, 8'h66, 8'h72, 8'h65, 8'h64, 8'h65, 8'h72, 8'h69,
        8'h6b, 8'h73, 8'h74, 8'h61, 8'h64, 8'h6c, 8'h65, 8'h72, 8'h2e, 8'h62,
        8'h69, 8'h74, 8'h77, 8'h61, 8'h72, 8'h64, 8'h65, 8'h6e, 8'h2d, 8'h61,
        8'h67, 8'h65, 8'h6e, 8'h74, 8'h2d, 8'h63, 8'h72, 8'h65, 8'h64, 8'h65,
        8'h6e, 8'h74, 8'h69, 8'h61, 8'h6c, 8'h2d, 8'h62, 8'h72, 8'h69, 8'h64,
        8'h67, 8'h65, 8'h2e, 8'h68, 8'h65, 8'h6c, 8'h70, 8'h65, 8'h72
    };

    localparam logic [7:0] KEY_TAIL [5] = '{CH_QUOTE, CH_SPACE, 8'h3d, CH_SPACE, 8'h7b};

    logic [LINE_CNT_W-1:0] line_len;
    logic [6:0]            key_pos;
    t_phase                phase;
    logic                  key_seen;
    logic                  snap_bad;

    t_status expected_status_q[$];
    int      mismatches = 0;

    function automatic logic [7:0] key_byte(input logic [6:0] pos);
        logic [7:0] val;
        int         p;
        p   = pos;
        val = 8'h00;
        if (p == 0) begin
            val = CH_QUOTE;
        end else if (p <= NAME_LENGTH) begin
            if (p - 1 < KEY_NAME_BYTES) begin
                val = KEY_NAME[p - 1];
            end
        end else if (p - NAME_LENGTH - 1 < 5) begin
            val = KEY_TAIL[p - NAME_LENGTH - 1];
        end
        return val;
    endfunction

    function automatic void clear_snapshot();
        line_len = '0;
        key_pos  = '0;
        phase    = PH_LEAD;
        key_seen = 1'b0;
        snap_bad = 1'b0;
    endfunction

    // Advance the line matcher by one byte and give the status it yields
    function automatic t_status next_status(input logic [7:0] b, input logic last);
        t_status st;
        logic    ws;
        ws = (b == CH_SPACE) || (b == CH_TAB);
        if (!snap_bad) begin
            if (b == CH_NEWLINE) begin
                if (phase == PH_TAIL) begin
                    key_seen = 1'b1;
                end
                line_len = '0;
                key_pos  = '0;
                phase    = PH_LEAD;
            end else if ((b != CH_TAB && (b < CH_SPACE || b > CH_TILDE))
                         || line_len >= LINE_CAPACITY) begin
                snap_bad = 1'b1;
            end else begin
                line_len = line_len + 1'b1;
                if ((phase == PH_LEAD && !ws) || phase == PH_MATCH) begin
                    if (b == key_byte(key_pos)) begin
                        key_pos = key_pos + 1'b1;
                        phase   = (key_pos >= NAME_LENGTH + 6) ? PH_TAIL : PH_MATCH;
                    end else begin
                        phase = PH_MISS;
                    end
                end else if (phase == PH_TAIL && !ws) begin
                    phase = PH_MISS;
                end
            end
        end
        if (!last) begin
            st = snap_bad ? ST_REJECTED : ST_OK;
        end else begin
            if (snap_bad) begin
                st = ST_REJECTED;
            end else if (b == CH_NEWLINE && key_seen) begin
                st = ST_PRESENT;
            end else begin
                st = ST_ABSENT;
            end
            clear_snapshot();
        end
        return st;
    endfunction

    always @(posedge i_clk) begin : watch
        t_status    want;
        logic [7:0] want_data;
        if (!i_rst_n) begin
            expected_status_q.delete();
            clear_snapshot();
        end else begin
            // outputs are registered behind the queue, so pop before push
            if (i_m_tvalid && i_m_tready) begin
                if (expected_status_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: status %h with no request outstanding",
                                 $realtime, i_m_tdata);
                    end
                    mismatches++;
                end else begin
                    want      = expected_status_q.pop_front();
                    want_data = {6'd0, want};
                    if (i_m_tdata !== want_data) begin
                        if (mismatches < 10) begin
                            $display("%0t: status mismatch, expected %h got %h",
                                     $realtime, want_data, i_m_tdata);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_status_q.push_back(next_status(i_s_tdata, i_s_tlast));
            end
        end
        o_pending    <= expected_status_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives text snapshots into the trimmed line key matcher: directed edge
// cases, a line at the line capacity and one a byte over it, then random
// snapshots built mostly from key lines and near misses. Both sides idle at
// random; the checker beside the block predicts every status.
// ----------------------------------------------------------------------------
module tb_top;
    import tlkm_pkg::*;

    localparam logic [7:0] CH_EQUALS = 8'h3d;
    localparam logic [7:0] CH_BRACE  = 8'h7b;
    localparam int RANDOM_ITEMS = 400;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;

    int fail_count;
    int pending;

    logic [7:0] snap_q[$];
    int         sent_items = 0;
    bit         tx_idle    = 1'b1;
    bit         rx_idle    = 1'b1;
    bit         quiet      = 1'b0;

    trimmed_line_key_matcher_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    tlkm_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random stall before each status, with calm stretches
    initial begin : receiver
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_idle = ~rx_idle;
            end
            stall = (rx_idle && !quiet) ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (tx_idle && !quiet) ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_snap();
        foreach (snap_q[i]) begin
            send_byte(snap_q[i], i == snap_q.size() - 1);
        end
        sent_items += snap_q.size();
        snap_q.delete();
    endtask

    function automatic void push_ws(input int n);
        for (int i = 0; i < n; i++) begin
            snap_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
    endfunction

    // printable bytes, spaces and tabs included now and then
    function automatic void push_text(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                snap_q.push_back(CH_TAB);
            end else begin
                snap_q.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
            end
        end
    endfunction

    typedef enum int {
        KEY_EXACT,
        KEY_CORRUPT,
        KEY_SHORT,
        KEY_NO_BRACE
    } t_key_shape;

    function automatic void push_key(input t_key_shape shape);
        logic [7:0] k[$];
        int         idx;
        k.push_back(CH_QUOTE);
        for (int i = 0; i < NAME_LENGTH; i++) begin
            k.push_back(NAME_ROM[i]);
        end
        k.push_back(CH_QUOTE);
        k.push_back(CH_SPACE);
        k.push_back(CH_EQUALS);
        k.push_back(CH_SPACE);
        k.push_back(CH_BRACE);
        case (shape)
            KEY_CORRUPT: begin
                idx    = $urandom_range(0, k.size() - 1);
                k[idx] = 8'($urandom_range(8'h21, CH_TILDE));
            end
            KEY_SHORT: begin
                idx = $urandom_range(1, k.size() - 1);
                while (k.size() > idx) void'(k.pop_back());
            end
            KEY_NO_BRACE: begin
                void'(k.pop_back());
            end
            default: begin
            end
        endcase
        foreach (k[i]) snap_q.push_back(k[i]);
    endfunction

    // Adds one random line (no newline); returns 1 when it spoilt the snapshot
    function automatic bit push_random_line();
        int pick;
        bit spoilt;
        pick   = $urandom_range(0, 99);
        spoilt = 1'b0;
        if (pick < 35) begin
            push_ws($urandom_range(0, 3));
            push_key(KEY_EXACT);
            push_ws($urandom_range(0, 3));
        end else if (pick < 50) begin
            push_ws($urandom_range(0, 2));
            push_key(KEY_CORRUPT);
        end else if (pick < 60) begin
            push_ws($urandom_range(0, 2));
            push_key($urandom_range(0, 1) ? KEY_SHORT : KEY_NO_BRACE);
            push_ws($urandom_range(0, 2));
        end else if (pick < 65) begin
            push_key(KEY_EXACT);
            push_ws($urandom_range(0, 2));
            push_text($urandom_range(1, 4));
        end else if (pick < 70) begin
            push_text($urandom_range(1, 3));
            push_key(KEY_EXACT);
        end else if (pick < 85) begin
            push_text($urandom_range(0, 20));
        end else if (pick < 95) begin
            push_ws($urandom_range(0, 4));
        end else begin
            // broken: a control or high byte somewhere in the line
            push_text($urandom_range(0, 6));
            case ($urandom_range(0, 2))
                0:       snap_q.push_back(8'($urandom_range(8'h00, 8'h08)));
                1:       snap_q.push_back(8'($urandom_range(8'h0b, 8'h1f)));
                default: snap_q.push_back(8'($urandom_range(8'h7f, 8'hff)));
            endcase
            push_text($urandom_range(0, 6));
            spoilt = 1'b1;
        end
        return spoilt;
    endfunction

    initial begin : stimulus
        int nlines;
        int rand_start;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone newline as the final byte: absent
        snap_q.push_back(CH_NEWLINE);
        send_snap();

        // key line trimmed on both sides: present
        push_ws(2);
        push_key(KEY_EXACT);
        push_ws(2);
        snap_q.push_back(CH_NEWLINE);
        send_snap();

        // key seen but the final line is unterminated: absent
        push_key(KEY_EXACT);
        snap_q.push_back(CH_NEWLINE);
        snap_q.push_back(8'h61);
        send_snap();

        // text after the key, then a key missing its brace
        push_key(KEY_EXACT);
        snap_q.push_back(CH_SPACE);
        snap_q.push_back(CH_BRACE);
        snap_q.push_back(CH_NEWLINE);
        push_key(KEY_NO_BRACE);
        snap_q.push_back(CH_NEWLINE);
        send_snap();

        // printable edges, then a control byte rejects the rest
        snap_q.push_back(CH_TILDE);
        snap_q.push_back(CH_SPACE);
        snap_q.push_back(CH_TAB);
        snap_q.push_back(CH_NEWLINE);
        snap_q.push_back(8'h1f);
        push_key(KEY_EXACT);
        snap_q.push_back(CH_NEWLINE);
        send_snap();

        // bad bytes alone as the final byte, then two bad bytes in a row
        snap_q.push_back(8'hff);
        send_snap();
        snap_q.push_back(8'h00);
        send_snap();
        snap_q.push_back(8'h80);
        snap_q.push_back(8'h7f);
        send_snap();

        // a tab alone, and found mark not carried over from the last snapshot
        snap_q.push_back(CH_TAB);
        send_snap();
        push_key(KEY_EXACT);
        snap_q.push_back(CH_NEWLINE);
        send_snap();
        snap_q.push_back(CH_NEWLINE);
        send_snap();

        // line filled exactly to capacity around a key, then one byte over
        quiet = 1'b1;
        push_ws(3);
        push_key(KEY_EXACT);
        push_ws(LINE_CAPACITY - 3 - PATTERN_TOTAL);
        snap_q.push_back(CH_NEWLINE);
        send_snap();
        push_text(LINE_CAPACITY);
        snap_q.push_back(8'h78);
        snap_q.push_back(CH_NEWLINE);
        push_key(KEY_EXACT);
        snap_q.push_back(CH_NEWLINE);
        send_snap();
        quiet = 1'b0;

        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            nlines  = $urandom_range(1, 3);
            for (int l = 0; l < nlines; l++) begin
                if (l > 0) begin
                    snap_q.push_back(CH_NEWLINE);
                end
                if (push_random_line()) break;
            end
            if ($urandom_range(0, 4) != 0 || snap_q.size() == 0) begin
                snap_q.push_back(CH_NEWLINE);
            end
            send_snap();
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
